// ===== rtl/core/tterm_pkg.sv =====
// Shared types, codes and helpers for the text terminal cell writer.
package tterm_pkg;

    // Default screen geometry.
    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    // Attribute byte after reset.
    localparam logic [7:0] COLOR_RESET = 8'h07;

    // Characters with a meaning of their own.
    localparam logic [7:0] CHR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHR_RETURN  = 8'h0D;
    localparam logic [7:0] CHR_SPACE   = 8'h20;

    // Operation codes.
    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_HEX   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] char_code;
        logic [6:0] read_col;
        logic [4:0] read_row;
    } in_item_t;

    typedef struct packed {
        logic [6:0] cursor_col;
        logic [4:0] cursor_row;
        logic [7:0] cell_char;
        logic [7:0] cell_color;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PUT,
        ST_COPY,
        ST_FILL,
        ST_CLEAR,
        ST_READ,
        ST_READ_WAIT,
        ST_DONE
    } tterm_state_t;

    // Upper-case hex digit for one nibble.
    function automatic logic [7:0] hex_digit(input logic [3:0] nibble);
        logic [7:0] digit;
        if (nibble < 4'd10)
        begin
            digit = 8'h30 + {4'h0, nibble};
        end
        else
        begin
            digit = 8'h37 + {4'h0, nibble};
        end
        return digit;
    endfunction

endpackage

// ===== rtl/core/tterm_mem.sv =====
// Screen cell memory: one write port, one read port, registered read data.
module tterm_mem
    import tterm_pkg::*;
#(
    parameter int CELLS  = COLUMNS_DEF * ROWS_DEF,
    parameter int ADDR_W = $clog2(COLUMNS_DEF * ROWS_DEF)
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [15:0]       wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [15:0]       rdata
);

    logic [15:0] cells [CELLS];
    logic [15:0] rdata_reg;

    // Write one cell
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            cells[waddr] <= wdata;
        end
    end

    // Read one cell into the registered read data
    always_ff @(posedge clk)
    begin
        rdata_reg <= cells[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/tterm_ctrl.sv =====
// Operation sequencer: cursor, put/hex/clear/read, and the scroll sweep.
module tterm_ctrl
    import tterm_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF,
    parameter int ADDR_W  = $clog2(COLUMNS_DEF * ROWS_DEF)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  in_item_t          in_item,
    input  logic              cfg_write,
    input  logic [7:0]        cfg_data,
    output logic              res_valid,
    input  logic              res_ready,
    output out_item_t         res,
    output logic              mem_we,
    output logic [ADDR_W-1:0] mem_waddr,
    output logic [15:0]       mem_wdata,
    output logic [ADDR_W-1:0] mem_raddr,
    input  logic [15:0]       mem_rdata
);

    localparam int COL_W  = $clog2(COLUMNS);
    localparam int LINE_W = $clog2(ROWS);
    localparam int CELLS  = COLUMNS * ROWS;
    localparam int COPY_N = COLUMNS * (ROWS - 1);

    tterm_state_t      state_reg, state_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [LINE_W-1:0] line_reg, line_next;
    logic [ADDR_W-1:0] cnt_reg, cnt_next;
    logic              hex_pend_reg, hex_pend_next;
    logic [7:0]        color_reg;
    logic [7:0]        ch_reg, ch_next;
    logic [7:0]        second_reg, second_next;
    logic [15:0]       cell_reg, cell_next;
    in_item_t          in_reg, in_next;

    logic              accept;
    logic [COL_W:0]    col_step;
    logic [LINE_W:0]   line_step;
    logic              scroll;
    logic [ADDR_W-1:0] cursor_addr;
    logic [ADDR_W-1:0] read_addr;
    logic              read_ok;
    logic [COL_W+6:0]  col_ext;
    logic [LINE_W+4:0] line_ext;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);

    // Linear addresses of the cursor cell and of the requested cell
    assign cursor_addr = ADDR_W'(32'(line_reg) * 32'(COLUMNS) + 32'(col_reg));
    assign read_addr   = ADDR_W'(32'(in_reg.read_row) * 32'(COLUMNS) + 32'(in_reg.read_col));
    assign read_ok     = (32'(in_reg.read_col) < 32'(COLUMNS))
                      && (32'(in_reg.read_row) < 32'(ROWS));

    // Cursor movement for the character in ch_reg
    always_comb
    begin
        col_step  = {1'b0, col_reg};
        line_step = {1'b0, line_reg};
        if (ch_reg == CHR_NEWLINE)
        begin
            line_step = line_step + 1'b1;
        end
        else if (ch_reg == CHR_RETURN)
        begin
            col_step = '0;
        end
        else
        begin
            col_step = col_step + 1'b1;
        end
        if (col_step >= (COL_W+1)'(COLUMNS))
        begin
            col_step  = '0;
            line_step = line_step + 1'b1;
        end
        scroll = (line_step >= (LINE_W+1)'(ROWS));
        if (scroll)
        begin
            line_step = (LINE_W+1)'(ROWS - 1);
        end
    end

    // Hold the attribute register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_reg <= COLOR_RESET;
        end
        else if (cfg_write)
        begin
            color_reg <= cfg_data;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            col_reg      <= '0;
            line_reg     <= '0;
            cnt_reg      <= '0;
            hex_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            col_reg      <= col_next;
            line_reg     <= line_next;
            cnt_reg      <= cnt_next;
            hex_pend_reg <= hex_pend_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        ch_reg     <= ch_next;
        second_reg <= second_next;
        cell_reg   <= cell_next;
        in_reg     <= in_next;
    end

    // Next state, memory port and result
    always_comb
    begin
        state_next    = state_reg;
        col_next      = col_reg;
        line_next     = line_reg;
        cnt_next      = cnt_reg;
        hex_pend_next = hex_pend_reg;
        ch_next       = ch_reg;
        second_next   = second_reg;
        cell_next     = cell_reg;
        in_next       = in_reg;
        mem_we        = 1'b0;
        mem_waddr     = cnt_reg;
        mem_wdata     = {color_reg, CHR_SPACE};
        mem_raddr     = read_addr;
        res_valid     = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    in_next       = in_item;
                    cnt_next      = '0;
                    cell_next     = '0;
                    hex_pend_next = 1'b0;
                    ch_next       = in_item.char_code;
                    case (in_item.operation)
                        OP_PUT:
                        begin
                            state_next = ST_PUT;
                        end
                        OP_HEX:
                        begin
                            ch_next       = hex_digit(in_item.char_code[7:4]);
                            second_next   = hex_digit(in_item.char_code[3:0]);
                            hex_pend_next = 1'b1;
                            state_next    = ST_PUT;
                        end
                        OP_CLEAR:
                        begin
                            state_next = ST_CLEAR;
                        end
                        OP_READ:
                        begin
                            state_next = ST_READ;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_PUT:
            begin
                // Store a printable byte at the cursor and move the cursor
                mem_we    = (ch_reg != CHR_NEWLINE) && (ch_reg != CHR_RETURN);
                mem_waddr = cursor_addr;
                mem_wdata = {color_reg, ch_reg};
                col_next  = col_step[COL_W-1:0];
                line_next = line_step[LINE_W-1:0];
                if (scroll)
                begin
                    cnt_next   = '0;
                    state_next = ST_COPY;
                end
                else if (hex_pend_reg)
                begin
                    ch_next       = second_reg;
                    hex_pend_next = 1'b0;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end

            ST_COPY:
            begin
                // Read a row below, write the cell fetched last cycle one row up
                mem_raddr = ADDR_W'(32'(cnt_reg) + 32'(COLUMNS));
                mem_we    = (cnt_reg != '0);
                mem_waddr = cnt_reg - 1'b1;
                mem_wdata = mem_rdata;
                if (32'(cnt_reg) == COPY_N)
                begin
                    state_next = ST_FILL;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            ST_FILL:
            begin
                // Blank the bottom row
                mem_we = 1'b1;
                if (32'(cnt_reg) == CELLS - 1)
                begin
                    if (hex_pend_reg)
                    begin
                        ch_next       = second_reg;
                        hex_pend_next = 1'b0;
                        state_next    = ST_PUT;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            ST_CLEAR:
            begin
                // Blank every cell, then home the cursor
                mem_we = 1'b1;
                if (32'(cnt_reg) == CELLS - 1)
                begin
                    col_next   = '0;
                    line_next  = '0;
                    state_next = ST_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            ST_READ:
            begin
                state_next = ST_READ_WAIT;
            end

            ST_READ_WAIT:
            begin
                cell_next  = read_ok ? mem_rdata : 16'h0000;
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result fields, cursor masked to the output widths
    assign col_ext  = (COL_W+7)'(col_reg);
    assign line_ext = (LINE_W+5)'(line_reg);
    assign res.cursor_col = col_ext[6:0];
    assign res.cursor_row = line_ext[4:0];
    assign res.cell_char  = cell_reg[7:0];
    assign res.cell_color = cell_reg[15:8];

`ifndef SYNTH
    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(col_reg) < COLUMNS)
        else $error("cursor column out of range");

    a_line_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(line_reg) < ROWS)
        else $error("cursor row out of range");

    a_we_states: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ST_PUT || state_reg == ST_COPY
                    || state_reg == ST_FILL || state_reg == ST_CLEAR))
        else $error("memory write outside a writing state");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != ST_IDLE))
        else $error("accepted transfer did not start work");
`endif

endmodule

// ===== rtl/core/text_terminal_cell_writer.sv =====
// Text terminal cell writer: a screen of character/attribute cells with a cursor.
// One transfer in gives one transfer out. Each put, hex print or read is handled
// by the sequencer stepping through the cell memory before its result goes to
// the result register. A clear writes every cell once. A put that moves past the
// bottom row scrolls the screen with a pipelined copy (one cell a cycle) followed
// by a bottom-row fill. The input side takes the next item as soon as the
// previous result sits in the output register. Cells read before any write since
// reset return undefined data; clear the screen first.
module text_terminal_cell_writer
    import tterm_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_item,
    input  logic      cfg_write,
    input  logic [7:0] cfg_data
);

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);

    logic              res_valid;
    logic              res_ready;
    out_item_t         res;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [15:0]       mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;
    logic [15:0]       mem_rdata;
    logic              out_valid_reg;
    out_item_t         out_item_reg;

    tterm_ctrl #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .ADDR_W  (ADDR_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    tterm_mem #(
        .CELLS  (CELLS),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Output slot is free when empty or being drained
    assign res_ready = !out_valid_reg || !out_stall;

    // Hold the result until the transfer completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    // Load result payload
    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_item_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the text terminal cell writer: directed table, then random traffic.
`timescale 1ns / 1ps

module tb_top;
    import tterm_pkg::*;

    localparam int COLS       = COLUMNS_DEF;
    localparam int LINES      = ROWS_DEF;
    localparam int CELLS      = COLS * LINES;
    localparam int IDLE_LIMIT = 20000;
    localparam int PHASES     = 5;
    localparam int PHASE_LEN  = 250;
    localparam logic [127:0] HEX_GLYPHS = "0123456789ABCDEF";

    typedef enum {ROW_OP, ROW_COLOR} row_kind_t;
    typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_HOLD} stall_mode_t;

    typedef struct {
        row_kind_t  kind;
        in_item_t   item;
        logic [7:0] color;
        bit         typed;
        out_item_t  want;
    } plan_row_t;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_item_t  in_item;
    logic      out_valid;
    logic      out_stall;
    out_item_t out_item;
    logic      cfg_write;
    logic [7:0] cfg_data;

    // Shadow screen, cursor and attribute
    logic [15:0] cell_mem [0:CELLS-1];
    bit          cell_written [0:CELLS-1];
    int          cur_col;
    int          cur_row;
    logic [7:0]  attr;

    out_item_t   term_reports_q [$];
    plan_row_t   directed_plan [$];

    int mismatches;
    int idle_cycles;
    int burst_left;
    int put_count;
    int hex_count;
    int clear_count;
    int read_count;
    int scroll_count;
    int color_settings;
    logic [7:0] phase_colors [PHASES];

    text_terminal_cell_writer #(
        .COLUMNS (COLS),
        .ROWS    (LINES)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    // Shift every row up and fill the bottom row with spaces
    function automatic void scroll_screen();
        for (int i = 0; i < CELLS - COLS; i++)
        begin
            cell_mem[i]     = cell_mem[i + COLS];
            cell_written[i] = cell_written[i + COLS];
        end
        for (int i = CELLS - COLS; i < CELLS; i++)
        begin
            cell_mem[i]     = {attr, CHR_SPACE};
            cell_written[i] = 1'b1;
        end
        scroll_count++;
    endfunction

    // Put one character at the cursor and advance it
    function automatic void place_char(logic [7:0] ch);
        int idx;
        idx = cur_row * COLS + cur_col;
        if (ch == CHR_NEWLINE)
            cur_row++;
        else if (ch == CHR_RETURN)
            cur_col = 0;
        else
        begin
            cell_mem[idx]     = {attr, ch};
            cell_written[idx] = 1'b1;
            cur_col++;
        end
        if (cur_col >= COLS)
        begin
            cur_col = 0;
            cur_row++;
        end
        if (cur_row >= LINES)
        begin
            scroll_screen();
            cur_row = LINES - 1;
        end
    endfunction

    // Apply one command to the shadow terminal and return the expected report
    function automatic out_item_t terminal_apply(in_item_t it);
        out_item_t rep;
        int        idx;
        rep = '0;
        case (it.operation)
            OP_PUT:
            begin
                place_char(it.char_code);
                put_count++;
            end
            OP_HEX:
            begin
                place_char(HEX_GLYPHS[8 * (15 - int'(it.char_code[7:4])) +: 8]);
                place_char(HEX_GLYPHS[8 * (15 - int'(it.char_code[3:0])) +: 8]);
                hex_count++;
            end
            OP_CLEAR:
            begin
                for (int i = 0; i < CELLS; i++)
                begin
                    cell_mem[i]     = {attr, CHR_SPACE};
                    cell_written[i] = 1'b1;
                end
                cur_col = 0;
                cur_row = 0;
                clear_count++;
            end
            OP_READ:
            begin
                if (it.read_col < COLS && it.read_row < LINES)
                begin
                    idx = int'(it.read_row) * COLS + int'(it.read_col);
                    rep.cell_char  = cell_mem[idx][7:0];
                    rep.cell_color = cell_mem[idx][15:8];
                end
                read_count++;
            end
            default:
            begin
            end
        endcase
        rep.cursor_col = cur_col[6:0];
        rep.cursor_row = cur_row[4:0];
        return rep;
    endfunction

    // Random command, weighted so the cursor reaches the bottom row and scrolls
    function automatic in_item_t gen_item();
        in_item_t it;
        int       pick;
        int       sel;
        it.operation = OP_READ;
        it.char_code = 8'($urandom_range(0, 255));
        it.read_col  = 7'($urandom_range(0, 127));
        it.read_row  = 5'($urandom_range(0, 31));
        pick = $urandom_range(0, 99);
        if (pick < 50)
        begin
            it.operation = OP_PUT;
            sel = $urandom_range(0, 99);
            if (sel < 30)
                it.char_code = CHR_NEWLINE;
            else if (sel < 38)
                it.char_code = CHR_RETURN;
        end
        else if (pick < 70)
            it.operation = OP_HEX;
        else if (pick < 71)
            it.operation = OP_CLEAR;
        else
        begin
            if ($urandom_range(0, 99) < 85)
            begin
                it.read_col = 7'($urandom_range(0, COLS - 1));
                it.read_row = 5'($urandom_range(0, LINES - 1));
            end
            // steer away from cells that were never written
            if (it.read_col < COLS && it.read_row < LINES &&
                !cell_written[int'(it.read_row) * COLS + int'(it.read_col)])
                it.read_col = 7'd127;
        end
        return it;
    endfunction

    function automatic plan_row_t op_row(logic [1:0] op, logic [7:0] ch,
                                         logic [6:0] col, logic [4:0] row);
        plan_row_t r;
        r.kind  = ROW_OP;
        r.item  = in_item_t'{op, ch, col, row};
        r.color = '0;
        r.typed = 1'b0;
        r.want  = '0;
        return r;
    endfunction

    function automatic plan_row_t checked_row(logic [1:0] op, logic [7:0] ch,
                                              logic [6:0] col, logic [4:0] row,
                                              logic [6:0] w_col, logic [4:0] w_row,
                                              logic [7:0] w_char, logic [7:0] w_color);
        plan_row_t r;
        r       = op_row(op, ch, col, row);
        r.typed = 1'b1;
        r.want  = out_item_t'{w_col, w_row, w_char, w_color};
        return r;
    endfunction

    function automatic plan_row_t color_row(logic [7:0] value);
        plan_row_t r;
        r       = op_row(OP_PUT, 8'h00, 7'd0, 5'd0);
        r.kind  = ROW_COLOR;
        r.color = value;
        return r;
    endfunction

    // Sender bursts with random gaps; called at a falling edge
    task automatic pace_sender();
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
    endtask

    // Offer one command, hold it until the transfer, then record its report
    task automatic send_command(in_item_t it, bit typed, out_item_t want);
        out_item_t pred;
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pred = terminal_apply(it);
        term_reports_q.push_back(typed ? want : pred);
        @(negedge clk);
    endtask

    // Drain all reports, then write the attribute register while idle
    task automatic set_text_color(logic [7:0] value);
        in_valid <= 1'b0;
        while (term_reports_q.size() != 0)
            @(negedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        attr = value;
        color_settings++;
    endtask

    // Receiver stall pattern
    initial
    begin
        stall_mode_t mode;
        int          len;
        out_stall = 1'b0;
        forever
        begin
            mode = stall_mode_t'($urandom_range(0, 3));
            len  = $urandom_range(10, 60);
            repeat (len)
            begin
                @(negedge clk);
                case (mode)
                    STALL_NONE:  out_stall <= 1'b0;
                    STALL_LIGHT: out_stall <= ($urandom_range(0, 99) < 30);
                    STALL_HEAVY: out_stall <= ($urandom_range(0, 99) < 70);
                    STALL_HOLD:  out_stall <= 1'b1;
                    default:     out_stall <= 1'b0;
                endcase
            end
        end
    end

    // Check each report against the oldest expectation; watch for a hang
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (out_valid && !out_stall)
            begin
                if (term_reports_q.size() == 0)
                begin
                    $error("report with no command outstanding: %h", out_item);
                    mismatches++;
                end
                else
                begin
                    want = term_reports_q.pop_front();
                    if (out_item.cursor_col !== want.cursor_col)
                    begin
                        $error("cursor_col: expected %0d, got %0d",
                               want.cursor_col, out_item.cursor_col);
                        mismatches++;
                    end
                    if (out_item.cursor_row !== want.cursor_row)
                    begin
                        $error("cursor_row: expected %0d, got %0d",
                               want.cursor_row, out_item.cursor_row);
                        mismatches++;
                    end
                    if (out_item.cell_char !== want.cell_char)
                    begin
                        $error("cell_char: expected %h, got %h",
                               want.cell_char, out_item.cell_char);
                        mismatches++;
                    end
                    if (out_item.cell_color !== want.cell_color)
                    begin
                        $error("cell_color: expected %h, got %h",
                               want.cell_color, out_item.cell_color);
                        mismatches++;
                    end
                end
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Main sequence
    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_item   = '0;
        cfg_write = 1'b0;
        cfg_data  = '0;
        mismatches     = 0;
        idle_cycles    = 0;
        burst_left     = 0;
        put_count      = 0;
        hex_count      = 0;
        clear_count    = 0;
        read_count     = 0;
        scroll_count   = 0;
        color_settings = 0;
        cur_col = 0;
        cur_row = 0;
        attr    = COLOR_RESET;
        for (int i = 0; i < CELLS; i++)
        begin
            cell_mem[i]     = '0;
            cell_written[i] = 1'b0;
        end

        // Directed table: typed rows carry their own expected report
        directed_plan.push_back(checked_row(OP_PUT, 8'h41, 7'd0, 5'd0,
                                            7'd1, 5'd0, 8'h00, 8'h00));
        directed_plan.push_back(checked_row(OP_READ, 8'h00, 7'd0, 5'd0,
                                            7'd1, 5'd0, 8'h41, COLOR_RESET));
        directed_plan.push_back(checked_row(OP_READ, 8'hFF, 7'd80, 5'd0,
                                            7'd1, 5'd0, 8'h00, 8'h00));
        directed_plan.push_back(checked_row(OP_READ, 8'h00, 7'd0, 5'd25,
                                            7'd1, 5'd0, 8'h00, 8'h00));
        directed_plan.push_back(checked_row(OP_READ, 8'hFF, 7'd127, 5'd31,
                                            7'd1, 5'd0, 8'h00, 8'h00));
        directed_plan.push_back(op_row(OP_PUT, 8'h00, 7'd127, 5'd31));
        directed_plan.push_back(checked_row(OP_PUT, CHR_RETURN, 7'd0, 5'd0,
                                            7'd0, 5'd0, 8'h00, 8'h00));
        directed_plan.push_back(checked_row(OP_PUT, CHR_NEWLINE, 7'd0, 5'd0,
                                            7'd0, 5'd1, 8'h00, 8'h00));
        directed_plan.push_back(op_row(OP_HEX, 8'hFF, 7'd0, 5'd0));
        directed_plan.push_back(op_row(OP_HEX, 8'h00, 7'd127, 5'd31));
        directed_plan.push_back(op_row(OP_HEX, 8'h9A, 7'd0, 5'd0));
        directed_plan.push_back(op_row(OP_READ, 8'h00, 7'd2, 5'd1));
        directed_plan.push_back(color_row(8'hFF));
        directed_plan.push_back(checked_row(OP_CLEAR, 8'hFF, 7'd127, 5'd31,
                                            7'd0, 5'd0, 8'h00, 8'h00));
        directed_plan.push_back(checked_row(OP_READ, 8'h00, 7'd79, 5'd24,
                                            7'd0, 5'd0, CHR_SPACE, 8'hFF));
        directed_plan.push_back(color_row(8'h00));
        directed_plan.push_back(checked_row(OP_PUT, 8'hFF, 7'd0, 5'd0,
                                            7'd1, 5'd0, 8'h00, 8'h00));
        directed_plan.push_back(checked_row(OP_READ, 8'h00, 7'd0, 5'd0,
                                            7'd1, 5'd0, 8'hFF, 8'h00));
        directed_plan.push_back(op_row(OP_PUT, CHR_NEWLINE, 7'd0, 5'd0));
        directed_plan.push_back(op_row(OP_HEX, 8'h5C, 7'd0, 5'd0));
        directed_plan.push_back(op_row(OP_READ, 8'h00, 7'd1, 5'd1));
        directed_plan.push_back(op_row(OP_READ, 8'h00, 7'd0, 5'd24));

        phase_colors[0] = 8'($urandom_range(0, 255));
        phase_colors[1] = 8'h00;
        phase_colors[2] = 8'hFF;
        phase_colors[3] = 8'($urandom_range(0, 255));
        phase_colors[4] = COLOR_RESET;

        // Hold reset, release on a falling edge
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_plan[i])
        begin
            if (directed_plan[i].kind == ROW_COLOR)
                set_text_color(directed_plan[i].color);
            else
            begin
                pace_sender();
                send_command(directed_plan[i].item, directed_plan[i].typed,
                             directed_plan[i].want);
            end
        end

        // Random phases, each under its own attribute
        for (int p = 0; p < PHASES; p++)
        begin
            set_text_color(phase_colors[p]);
            for (int i = 0; i < PHASE_LEN; i++)
            begin
                pace_sender();
                send_command(gen_item(), 1'b0, '0);
            end
        end

        // Drain and settle
        in_valid <= 1'b0;
        while (term_reports_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Ran %0d puts, %0d hex prints, %0d clears, %0d reads",
                 put_count, hex_count, clear_count, read_count);
        $display("Screen scrolled %0d times across %0d attribute writes",
                 scroll_count, color_settings);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
